// File: rtl/ede_pkg.sv
package ede_pkg;

  localparam int SLOT_W = 11;
  localparam int ZZ_W   = 17;
  localparam int NZ     = 5;

  // change-mask bits
  localparam int MASK_POS_BIT  = 0;
  localparam int MASK_HEAD_BIT = 1;
  localparam int MASK_HUE_BIT  = 2;

  localparam logic [7:0] LOW7 = 8'h7F;
  localparam logic [7:0] MORE = 8'h80;

  // varint field order
  localparam logic [2:0] ZI_X = 3'd0;
  localparam logic [2:0] ZI_Y = 3'd1;
  localparam logic [2:0] ZI_Z = 3'd2;
  localparam logic [2:0] ZI_U = 3'd3;
  localparam logic [2:0] ZI_V = 3'd4;

  typedef enum logic [1:0] {
    PH_ID,
    PH_MASK,
    PH_VAL,
    PH_HUE
  } ph_t;

  typedef struct packed {
    logic                      command;
    logic [SLOT_W-1:0]         slot;
    logic [31:0]               entity_id;
    logic [15:0]               pos_x;
    logic [15:0]               pos_y;
    logic [15:0]               pos_z;
    logic signed [15:0]        head_u;
    logic signed [15:0]        head_v;
    logic [7:0]                colour;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       id_mismatch;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ident;
    logic [15:0] pos_z;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic [15:0] head_v;
    logic [15:0] head_u;
    logic [7:0]  hue;
  } base_t;

  typedef struct packed {
    logic                      err;
    logic [31:0]               ident;
    logic [2:0]                mask;
    logic [NZ-1:0][ZZ_W-1:0]   zz;
    logic [7:0]                hue;
  } ser_item_t;

  function automatic logic [ZZ_W-1:0] zigzag(input logic [ZZ_W-1:0] d);
    return {d[ZZ_W-2:0], 1'b0} ^ {ZZ_W{d[ZZ_W-1]}};
  endfunction

endpackage

// File: rtl/ede_serial.sv
module ede_serial (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld,
  input  ede_pkg::ser_item_t item,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output ede_pkg::out_item_t out_data
);
  import ede_pkg::*;

  ser_item_t       item_r;
  ph_t             ph_r, ph_nxt;
  logic            busy_r;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0]      k_r, k_nxt;
  logic [ZZ_W-1:0] cur_r, cur_nxt, cur_rest;
  logic            out_valid_r;
  out_item_t       out_r;
  logic            emit;
  logic            sel_val;
  logic [7:0]      byte_c;
  logic            last_c, mism_c;

  assign emit     = busy_r & (~out_valid_r | ~out_stall);
  assign free     = ~busy_r | (emit & last_c);
  assign cur_rest = cur_r >> 7;

  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    k_nxt   = k_r;
    cur_nxt = cur_r;
    sel_val = 1'b0;
    byte_c  = '0;
    last_c  = 1'b0;
    mism_c  = 1'b0;
    unique case (ph_r)
      PH_ID: begin
        if (item_r.err) begin
          last_c = 1'b1;
          mism_c = 1'b1;
        end else begin
          byte_c  = item_r.ident[8*cnt_r +: 8];
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd3) ph_nxt = PH_MASK;
        end
      end
      PH_MASK: begin
        byte_c = {5'd0, item_r.mask};
        if (item_r.mask[MASK_POS_BIT]) begin
          ph_nxt  = PH_VAL;
          k_nxt   = ZI_X;
          sel_val = 1'b1;
        end else if (item_r.mask[MASK_HEAD_BIT]) begin
          ph_nxt  = PH_VAL;
          k_nxt   = ZI_U;
          sel_val = 1'b1;
        end else if (item_r.mask[MASK_HUE_BIT]) begin
          ph_nxt = PH_HUE;
        end else begin
          last_c = 1'b1;
        end
      end
      PH_VAL: begin
        byte_c = (8'(cur_r) & LOW7) | ((cur_rest != '0) ? MORE : 8'd0);
        if (cur_rest != '0) begin
          cur_nxt = cur_rest;
        end else begin
          // current varint done, pick the next field
          case (k_r) inside
            ZI_X, ZI_Y, ZI_U: begin
              k_nxt   = k_r + 3'd1;
              sel_val = 1'b1;
            end
            ZI_Z: begin
              if (item_r.mask[MASK_HEAD_BIT]) begin
                k_nxt   = ZI_U;
                sel_val = 1'b1;
              end else if (item_r.mask[MASK_HUE_BIT]) begin
                ph_nxt = PH_HUE;
              end else begin
                last_c = 1'b1;
              end
            end
            default: begin
              if (item_r.mask[MASK_HUE_BIT]) ph_nxt = PH_HUE;
              else last_c = 1'b1;
            end
          endcase
        end
      end
      PH_HUE: begin
        byte_c = item_r.hue;
        last_c = 1'b1;
      end
      default: begin
        last_c = 1'b1;
      end
    endcase
    if (sel_val) cur_nxt = item_r.zz[k_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_ID;
    end else if (ld) begin
      ph_r <= PH_ID;
    end else if (emit) begin
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld) busy_r <= 1'b1;
      else if (emit && last_c) busy_r <= 1'b0;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      item_r <= item;
      cnt_r  <= 2'd0;
    end else if (emit) begin
      cnt_r <= cnt_nxt;
      k_r   <= k_nxt;
      cur_r <= cur_nxt;
    end
    if (emit) out_r <= '{out_byte: byte_c, last: last_c, id_mismatch: mism_c};
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/entity_delta_varint_encoder.sv
// Entity delta encoder with a per-slot baseline memory.
// in_data carries one entity record and a command. A load stores the record
// as the baseline of its slot and gives no output. An encode gives the id as
// four little-endian bytes, a change-mask byte, zigzag varint deltas for every
// axis of each changed position or heading group and the raw hue byte if the
// hue changed, then makes the record the new baseline. An id that differs from the
// baseline gives one item with out_byte zero, last and id_mismatch set, and
// the baseline stays as it was. Slot numbers wrap modulo SLOT_COUNT.
// The first byte of an encode passes the read stage and the serialiser item
// register before it sits in the output register. The byte serialiser sends one
// byte per cycle unless the output stalls: an encode gives 5 to 21 bytes, a
// mismatch 1; the next item is taken while the previous record is still going out.
// A read-modify-write on the same slot back to back is forwarded.
// Reset clears the pipeline and output valid flags only; the baseline memory
// is not cleared, and a slot must be loaded before it is encoded.
// While out_stall is high the output item holds and in_stall rises once the
// serialiser and the read stage are full.
module entity_delta_varint_encoder #(
  parameter int SLOT_COUNT = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ede_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ede_pkg::out_item_t out_data
);
  import ede_pkg::*;

  localparam int AW        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_SPAN = 2 ** SLOT_W;

  base_t           mem [SLOT_COUNT];
  base_t           rd_r, fwd_rec_r, base, b_rec;
  logic            fwd_r;
  logic            b_valid_r;
  in_item_t        b_item_r;
  logic [AW-1:0]   b_idx_r, slot_idx;
  logic [SLOT_W-1:0] rem;
  logic            accept, b_adv, b_wr, match, ser_ld, ser_free;
  ser_item_t       ser_item;
  logic [2:0]      mask;

  // slot modulo SLOT_COUNT by conditional subtraction of shifted multiples
  always_comb begin
    rem = in_data.slot;
    for (int k = SLOT_W - 1; k >= 0; k--) begin
      if ((SLOT_COUNT << k) < SLOT_SPAN) begin
        if (rem >= SLOT_W'(SLOT_COUNT << k)) rem = rem - SLOT_W'(SLOT_COUNT << k);
      end
    end
  end
  assign slot_idx = AW'(rem);

  assign accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (b_wr) mem[b_idx_r] <= b_rec;
    if (accept) rd_r <= mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (accept) begin
      b_valid_r <= 1'b1;
    end else if (b_adv) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_item_r  <= in_data;
      b_idx_r   <= slot_idx;
      // same-slot write in this edge is missed by the read
      fwd_r     <= b_wr && (b_idx_r == slot_idx);
      fwd_rec_r <= b_rec;
    end
  end

  assign base = fwd_r ? fwd_rec_r : rd_r;

  assign b_rec = '{ident:  b_item_r.entity_id,
                   pos_z:  b_item_r.pos_z,
                   pos_y:  b_item_r.pos_y,
                   pos_x:  b_item_r.pos_x,
                   head_v: b_item_r.head_v,
                   head_u: b_item_r.head_u,
                   hue:    b_item_r.colour};

  assign match = (base.ident == b_item_r.entity_id);

  always_comb begin
    mask                = '0;
    mask[MASK_POS_BIT]  = {b_rec.pos_z, b_rec.pos_y, b_rec.pos_x}
                          != {base.pos_z, base.pos_y, base.pos_x};
    mask[MASK_HEAD_BIT] = {b_rec.head_v, b_rec.head_u} != {base.head_v, base.head_u};
    mask[MASK_HUE_BIT]  = b_rec.hue != base.hue;
  end

  always_comb begin
    ser_item.err   = ~match;
    ser_item.ident = b_item_r.entity_id;
    ser_item.mask  = mask;
    ser_item.hue   = b_item_r.colour;
    ser_item.zz[ZI_X] = zigzag({1'b0, b_rec.pos_x} - {1'b0, base.pos_x});
    ser_item.zz[ZI_Y] = zigzag({1'b0, b_rec.pos_y} - {1'b0, base.pos_y});
    ser_item.zz[ZI_Z] = zigzag({1'b0, b_rec.pos_z} - {1'b0, base.pos_z});
    ser_item.zz[ZI_U] = zigzag({b_rec.head_u[15], b_rec.head_u}
                               - {base.head_u[15], base.head_u});
    ser_item.zz[ZI_V] = zigzag({b_rec.head_v[15], b_rec.head_v}
                               - {base.head_v[15], base.head_v});
  end

  assign b_adv    = b_valid_r & (~b_item_r.command | ser_free);
  assign b_wr     = b_adv & (~b_item_r.command | match);
  assign ser_ld   = b_adv & b_item_r.command;
  assign in_stall = b_valid_r & ~b_adv;

  ede_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ser_ld),
    .item      (ser_item),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !b_valid_r |-> !in_stall)
    else $error("stall raised with empty read stage");

  a_no_write_on_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    (b_wr && b_item_r.command) |-> match)
    else $error("baseline written on id mismatch");

  a_mismatch_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.id_mismatch) |-> (out_data.last && out_data.out_byte == 8'd0))
    else $error("mismatch item not a lone zero byte");

  a_forward_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && b_wr && (b_idx_r == slot_idx)) |=> fwd_r)
    else $error("same-slot update not forwarded");

endmodule

// File: dv/entity_delta_varint_encoder_test.sv
module entity_delta_varint_encoder_test;
  import ede_pkg::*;

  localparam int SLOT_COUNT = 2048;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT = 10;
  localparam int HOT_SLOTS = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // predictor state
  base_t baseline_mem [SLOT_COUNT];
  bit slot_loaded [SLOT_COUNT];
  int loaded_slots [$];
  out_item_t pending_bytes [$];

  int mismatches = 0;
  int idle_cycles = 0;

  // sender pacing
  int gap_max = 0;
  int burst_max = 1;
  int burst_left = 0;
  int prev_slot = -1;

  // receiver pacing
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int style_left = 0;
  int phase = 0;
  rx_style_t rx_style = RX_FREE;

  entity_delta_varint_encoder #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  function automatic void store_baseline(input in_item_t rec);
    int s;
    s = rec.slot;
    baseline_mem[s].ident = rec.entity_id;
    baseline_mem[s].pos_x = rec.pos_x;
    baseline_mem[s].pos_y = rec.pos_y;
    baseline_mem[s].pos_z = rec.pos_z;
    baseline_mem[s].head_u = rec.head_u;
    baseline_mem[s].head_v = rec.head_v;
    baseline_mem[s].hue = rec.colour;
    if (!slot_loaded[s]) begin
      slot_loaded[s] = 1'b1;
      loaded_slots = {loaded_slots, s};
    end
  endfunction

  // works out the byte stream that one accepted record produces
  function automatic void encode_entity(input in_item_t rec);
    base_t old;
    logic [7:0] bytes [$];
    logic [2:0] chg;
    int deltas [5];
    logic [31:0] zz;
    logic [7:0] b;
    out_item_t item;
    int k;
    if (rec.command == CMD_LOAD) begin
      store_baseline(rec);
      return;
    end
    old = baseline_mem[int'(rec.slot)];
    if (old.ident != rec.entity_id) begin
      item = '{out_byte: 8'h00, last: 1'b1, id_mismatch: 1'b1};
      pending_bytes = {pending_bytes, item};
      return;
    end
    chg = '0;
    chg[MASK_POS_BIT] = {rec.pos_x, rec.pos_y, rec.pos_z} != {old.pos_x, old.pos_y, old.pos_z};
    chg[MASK_HEAD_BIT] = {rec.head_u, rec.head_v} != {old.head_u, old.head_v};
    chg[MASK_HUE_BIT] = rec.colour != old.hue;
    for (k = 0; k < 4; k++) begin
      b = rec.entity_id[8*k +: 8];
      bytes = {bytes, b};
    end
    b = {5'b0, chg};
    bytes = {bytes, b};
    deltas[0] = int'(rec.pos_x) - int'(old.pos_x);
    deltas[1] = int'(rec.pos_y) - int'(old.pos_y);
    deltas[2] = int'(rec.pos_z) - int'(old.pos_z);
    deltas[3] = int'(rec.head_u) - int'($signed(old.head_u));
    deltas[4] = int'(rec.head_v) - int'($signed(old.head_v));
    for (k = 0; k < 5; k++) begin
      if ((k < 3 && chg[MASK_POS_BIT]) || (k >= 3 && chg[MASK_HEAD_BIT])) begin
        zz = {deltas[k][30:0], 1'b0} ^ {32{deltas[k][31]}};
        do begin
          b = zz[7:0] & LOW7;
          zz = zz >> 7;
          if (zz != 0) b = b | MORE;
          bytes = {bytes, b};
        end while (zz != 0);
      end
    end
    if (chg[MASK_HUE_BIT]) begin
      b = rec.colour;
      bytes = {bytes, b};
    end
    foreach (bytes[i]) begin
      item = '{out_byte: bytes[i], last: (i == bytes.size() - 1), id_mismatch: 1'b0};
      pending_bytes = {pending_bytes, item};
    end
    store_baseline(rec);
  endfunction

  function automatic in_item_t make_record(input logic cmd, input int s,
                                           input logic [31:0] id,
                                           input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] z, input logic [15:0] u,
                                           input logic [15:0] v, input logic [7:0] hue);
    in_item_t rec;
    rec.command = cmd;
    rec.slot = SLOT_W'(s);
    rec.entity_id = id;
    rec.pos_x = x;
    rec.pos_y = y;
    rec.pos_z = z;
    rec.head_u = u;
    rec.head_v = v;
    rec.colour = hue;
    return rec;
  endfunction

  function automatic in_item_t record_from_baseline(input int s);
    base_t b;
    b = baseline_mem[s];
    return make_record(CMD_ENCODE, s, b.ident, b.pos_x, b.pos_y, b.pos_z,
                       b.head_u, b.head_v, b.hue);
  endfunction

  // small step, full random, extreme or unchanged
  function automatic logic [15:0] nudge16(input logic [15:0] v);
    case ($urandom_range(3))
      0: return v;
      1: return v + 16'($urandom_range(400)) - 16'd200;
      2: return 16'($urandom);
      default: begin
        case ($urandom_range(3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t random_record();
    in_item_t rec;
    int pick;
    int s;
    logic [31:0] flip;
    pick = $urandom_range(99);
    if (loaded_slots.size() == 0 || pick < 25) begin
      s = $urandom_range(1) ? $urandom_range(HOT_SLOTS - 1) : $urandom_range(SLOT_COUNT - 1);
      return make_record(CMD_LOAD, s, $urandom, 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    end
    if (pick < 55 && prev_slot >= 0 && slot_loaded[prev_slot]) s = prev_slot;
    else s = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
    rec = record_from_baseline(s);
    if (pick < 33) begin
      flip = $urandom;
      if (flip == 0) flip = 32'd1;
      rec.entity_id = rec.entity_id ^ flip;
    end
    if ($urandom_range(1)) begin
      rec.pos_x = nudge16(rec.pos_x);
      rec.pos_y = nudge16(rec.pos_y);
      rec.pos_z = nudge16(rec.pos_z);
    end
    if ($urandom_range(1)) begin
      rec.head_u = nudge16(rec.head_u);
      rec.head_v = nudge16(rec.head_v);
    end
    if ($urandom_range(1)) rec.colour = 8'($urandom);
    return rec;
  endfunction

  // called just after a rising edge; returns after the edge that took the item and any random gap
  task automatic offer_record(input in_item_t rec);
    int gap;
    in_valid <= 1'b1;
    in_data <= rec;
    do begin
      @(negedge clk);
    end while (in_stall);
    @(posedge clk);
    encode_entity(rec);
    prev_slot = rec.slot;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(gap_max);
      burst_left = $urandom_range(burst_max - 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic test_directed_records();
    gap_max = 0;
    burst_max = 1;
    offer_record(make_record(CMD_LOAD, 0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00));
    offer_record(record_from_baseline(0));
    // largest record: every group changed by its widest step
    offer_record(make_record(CMD_ENCODE, 0, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'h8000, 16'h7FFF, 8'hFF));
    offer_record(make_record(CMD_ENCODE, 0, 32'h0, 16'h0, 16'h0, 16'h0,
                             16'h7FFF, 16'h8001, 8'h00));
    offer_record(make_record(CMD_LOAD, SLOT_COUNT - 1, 32'hFFFF_FFFF, 16'h1234, 16'h8000,
                             16'h0100, 16'hFFFF, 16'h0001, 8'h5A));
    // position only: one, one and three byte varints
    offer_record(make_record(CMD_ENCODE, SLOT_COUNT - 1, 32'hFFFF_FFFF, 16'h1235, 16'h7FC0,
                             16'h2100, 16'hFFFF, 16'h0001, 8'h5A));
    offer_record(make_record(CMD_ENCODE, SLOT_COUNT - 1, 32'hFFFF_FFFF, 16'h1235, 16'h7FC0,
                             16'h2100, 16'h0000, 16'hFFC0, 8'h5A));
    offer_record(make_record(CMD_ENCODE, SLOT_COUNT - 1, 32'hFFFF_FFFF, 16'h1235, 16'h7FC0,
                             16'h2100, 16'h0000, 16'hFFC0, 8'hA5));
    wait_quiet();
  endtask

  task automatic test_id_mismatch();
    in_item_t rec;
    gap_max = 2;
    burst_max = 3;
    rec = record_from_baseline(SLOT_COUNT - 1);
    rec.entity_id = 32'h0;
    rec.pos_x = 16'hFFFF;
    offer_record(rec);
    rec.entity_id = 32'h7FFF_FFFF;
    rec.colour = 8'h00;
    offer_record(rec);
    // baseline must be untouched, so no change is reported
    offer_record(record_from_baseline(SLOT_COUNT - 1));
    wait_quiet();
  endtask

  task automatic test_same_slot_back_to_back();
    in_item_t rec;
    gap_max = 0;
    burst_max = 1;
    offer_record(make_record(CMD_LOAD, 5, 32'h0BAD_F00D, 16'h4000, 16'h0010, 16'hC000,
                             16'h1000, 16'hF000, 8'h33));
    rec = record_from_baseline(5);
    rec.pos_x = rec.pos_x + 16'd1;
    offer_record(rec);
    rec = record_from_baseline(5);
    rec.head_v = rec.head_v - 16'sd300;
    rec.colour = rec.colour ^ 8'h01;
    offer_record(rec);
    offer_record(make_record(CMD_LOAD, 5, 32'h0000_0005, 16'h0001, 16'h0002, 16'h0003,
                             16'h0004, 16'h0005, 8'h06));
    rec = record_from_baseline(5);
    rec.pos_z = 16'hFFF0;
    offer_record(rec);
    rec.entity_id = 32'h0BAD_F00D;
    offer_record(rec);
    offer_record(record_from_baseline(5));
    wait_quiet();
  endtask

  // the receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_output_hold_off();
    gap_max = 0;
    burst_max = 1;
    hold_requests <= hold_requests + 1;
    repeat (40) offer_record(random_record());
    wait_quiet();
  endtask

  task automatic test_random_traffic();
    int n;
    for (n = 0; n < 300; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(3))
          0: gap_max = 0;
          1: gap_max = 2;
          2: gap_max = 6;
          default: gap_max = 12;
        endcase
        burst_max = $urandom_range(1, 12);
      end
      offer_record(random_record());
    end
    wait_quiet();
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        rx_style = rx_style_t'($urandom_range(3));
        style_left = $urandom_range(40, 160);
      end else begin
        style_left = style_left - 1;
      end
      phase = (phase + 1) % 5;
      case (rx_style)
        RX_FREE: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(99) < 30);
        RX_HEAVY: out_stall <= ($urandom_range(99) < 75);
        default: out_stall <= (phase < 3);
      endcase
    end
  end

  // checks each item taken on the result side, sampled away from the active edge
  always @(negedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("unexpected item: byte %02h last %0b flag %0b",
                   out_data.out_byte, out_data.last, out_data.id_mismatch);
        end
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (want.out_byte !== out_data.out_byte || want.last !== out_data.last ||
            want.id_mismatch !== out_data.id_mismatch) begin
          if (mismatches < REPORT_LIMIT) begin
            $display({"item mismatch: expected byte %02h last %0b flag %0b, ",
                      "got byte %02h last %0b flag %0b"},
                     want.out_byte, want.last, want.id_mismatch,
                     out_data.out_byte, out_data.last, out_data.id_mismatch);
          end
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_records();
    test_id_mismatch();
    test_same_slot_back_to_back();
    test_output_hold_off();
    test_random_traffic();
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
